// ----- rtl/bpd_pkg.sv -----
// Shared types and constants for the byte pair decoder.
// No dependencies; the top, the front end and the back end import this package.
package bpd_pkg;

   localparam int STACK_DEPTH = 4096;
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int SP_W = STK_AW + 1;
   localparam int PAIR_ENTRIES = 256;
   localparam int HEADER_BYTES = 12;
   localparam int FLAG_BYTE = 4;
   localparam int LITERAL_LIMIT = 127;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BUSY     = 2'd1;
   localparam logic [1:0] ST_IDLE     = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_COUNT,
      PH_PAIR,
      PH_LENGTH,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_RESTART,
      KIND_CONTINUE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } cmd_type;

endpackage

// ----- rtl/bpd_if.sv -----
// Handshake channels of the byte pair decoder: request and response.
// Depends on nothing.
interface bpd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic       stream_start;
   modport source (output valid, operation, data_byte, stream_start, input ready);
   modport sink (input valid, operation, data_byte, stream_start, output ready);
endinterface

interface bpd_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] decoded_byte;
   logic       pending;
   logic [1:0] status;
   modport source (output valid, byte_valid, decoded_byte, pending, status, input ready);
   modport sink (input valid, byte_valid, decoded_byte, pending, status, output ready);
endinterface

// ----- rtl/byte_pair_decoder_top.sv -----
// Byte pair decoder: a streaming byte-pair-encoding decompressor that takes one compressed
// byte or one continue tick per request transfer and returns exactly one response transfer
// for each. A two-entry queue in the front end takes requests while the back end works, and
// a response register lets the back end finish the next item while a response waits. A count
// byte that opens a run of n literal entries writes one table entry per cycle. A data byte
// or a continue tick follows left links in the pair table, each link one registered read of
// the table. After reset the block is ready at once; the pair table and the expansion stack
// hold nothing defined until the stream writes them.
// Depends on bpd_pkg, bpd_if, bpd_front and bpd_back.
module byte_pair_decoder_top (
   input  logic      clock,
   input  logic      reset,
   bpd_req_if.sink   req_ch,
   bpd_rsp_if.source rsp_ch
);
   import bpd_pkg::*;

   // Classified items pass from the front end to the back end through this handshake.
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   bpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   bpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_ch    (rsp_ch)
   );

   // A response without a literal carries a zero byte.
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.byte_valid |-> rsp_ch.decoded_byte == 8'd0)
      else $error("decoded byte not zero without literal");

   // Ignored items and overflows never deliver a literal.
   a_no_literal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_OK |-> !rsp_ch.byte_valid)
      else $error("literal delivered with error status");

   // An overflow empties the stack, so nothing stays pending.
   a_overflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_OVERFLOW |-> !rsp_ch.pending)
      else $error("pending after stack overflow");

endmodule

// ----- rtl/bpd_front.sv -----
// Front end: accepts request transfers, classifies them and queues them.
// Depends on bpd_pkg and bpd_req_if.
module bpd_front (
   input  logic            clock,
   input  logic            reset,
   bpd_req_if.sink         req_ch,
   output logic            cmd_valid,
   output bpd_pkg::cmd_type cmd,
   input  logic            cmd_ready
);
   import bpd_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;
   cmd_type    entry;

   always_comb begin
      if (req_ch.operation) begin
         entry.kind = KIND_CONTINUE;
      end else if (req_ch.stream_start) begin
         entry.kind = KIND_RESTART;
      end else begin
         entry.kind = KIND_BYTE;
      end
      entry.data = req_ch.data_byte;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd = q_ff[rd_ptr_ff];
   assign pop = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ----- rtl/bpd_back.sv -----
// Back end: stream parser, pair table, expansion stack and response register.
// Depends on bpd_pkg and bpd_rsp_if.
module bpd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  bpd_pkg::cmd_type cmd,
   output logic             cmd_ready,
   bpd_rsp_if.source        rsp_ch
);
   import bpd_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_POP, S_CHK, S_FILL, S_FIN} state_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             short_ff, short_in;
   logic [8:0]       idx_ff, idx_in;
   logic [7:0]       pr_ff, pr_in;
   logic             aw_ff, aw_in;
   logic [31:0]      bbl_ff, bbl_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [7:0]       c_ff, c_in;
   logic [7:0]       run_ff, run_in;
   logic             res_valid_ff, res_valid_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             ov_ff, ov_in;
   logic             o_bv_ff, o_bv_in;
   logic [7:0]       o_byte_ff, o_byte_in;
   logic             o_pend_ff, o_pend_in;
   logic [1:0]       o_stat_ff, o_stat_in;

   logic [7:0]       left_mem [PAIR_ENTRIES];
   logic [7:0]       right_mem [PAIR_ENTRIES];
   logic [7:0]       stack_mem [STACK_DEPTH];
   logic [7:0]       rd_left_ff;
   logic [7:0]       rd_right_ff;
   logic [7:0]       stk_rd_ff;

   logic [7:0]       tbl_raddr;
   logic             lw_en;
   logic [7:0]       lw_data;
   logic             rw_en;
   logic             sw_en;
   logic [SP_W-1:0]  sp_dec;
   logic [STK_AW-1:0] stk_raddr;

   assign sp_dec = sp_ff - 1'b1;
   assign stk_raddr = sp_dec[STK_AW-1:0];

   always_comb begin
      phase_type  ph;
      logic [3:0] cnt;
      logic       shortv;
      logic [7:0] b;
      logic       done_entry;
      logic [8:0] idx_nx;
      logic [7:0] pr_nx;
      logic [31:0] len_nx;
      logic [3:0] cnt_nx;

      state_in      = state_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      short_in      = short_ff;
      idx_in        = idx_ff;
      pr_in         = pr_ff;
      aw_in         = aw_ff;
      bbl_in        = bbl_ff;
      sp_in         = sp_ff;
      c_in          = c_ff;
      run_in        = run_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      ov_in         = ov_ff && !rsp_ch.ready;
      o_bv_in       = o_bv_ff;
      o_byte_in     = o_byte_ff;
      o_pend_in     = o_pend_ff;
      o_stat_in     = o_stat_ff;
      tbl_raddr     = c_ff;
      lw_en         = 1'b0;
      lw_data       = cmd.data;
      rw_en         = 1'b0;
      sw_en         = 1'b0;
      cmd_ready     = 1'b0;
      ph            = phase_ff;
      cnt           = cnt_ff;
      shortv        = short_ff;
      b             = cmd.data;
      done_entry    = 1'b0;
      idx_nx        = idx_ff + 9'd1;
      pr_nx         = (pr_ff != 8'd0) ? pr_ff - 8'd1 : 8'd0;
      len_nx        = bbl_ff | ({24'd0, b} << {cnt_ff[1:0], 3'b000});
      cnt_nx        = cnt_ff + 4'd1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_ready     = 1'b1;
               res_valid_in  = 1'b0;
               res_status_in = ST_OK;
               state_in      = S_FIN;
               if (cmd.kind == KIND_CONTINUE) begin
                  if (sp_ff == '0) begin
                     res_status_in = ST_IDLE;
                  end else begin
                     sp_in    = sp_dec;
                     state_in = S_POP;
                  end
               end else if (cmd.kind == KIND_BYTE && sp_ff != '0) begin
                  res_status_in = ST_BUSY;
               end else begin
                  if (cmd.kind == KIND_RESTART) begin
                     ph     = PH_HEADER;
                     cnt    = 4'd0;
                     shortv = 1'b0;
                     sp_in  = '0;
                  end
                  phase_in = ph;
                  cnt_in   = cnt;
                  short_in = shortv;
                  cnt_nx   = cnt + 4'd1;
                  unique case (ph)
                     PH_HEADER: begin
                        if (cnt == 4'(FLAG_BYTE)) short_in = b[0];
                        if (cnt_nx >= 4'(HEADER_BYTES)) begin
                           cnt_in   = 4'd0;
                           phase_in = PH_COUNT;
                           idx_in   = 9'd0;
                           pr_in    = 8'd0;
                           aw_in    = 1'b0;
                        end else begin
                           cnt_in = cnt_nx;
                        end
                     end
                     PH_COUNT: begin
                        if (b > 8'(LITERAL_LIMIT)) begin
                           run_in   = b - 8'(LITERAL_LIMIT);
                           state_in = S_FILL;
                        end else begin
                           pr_in = b + 8'd1;
                           if (idx_ff[8]) begin
                              idx_in   = 9'(PAIR_ENTRIES);
                              pr_in    = 8'd0;
                              phase_in = PH_LENGTH;
                              cnt_in   = 4'd0;
                              bbl_in   = 32'd0;
                           end else begin
                              phase_in = PH_PAIR;
                              aw_in    = 1'b0;
                           end
                        end
                     end
                     PH_PAIR: begin
                        if (aw_ff) begin
                           rw_en      = 1'b1;
                           done_entry = 1'b1;
                        end else begin
                           lw_en = 1'b1;
                           if (b != idx_ff[7:0]) aw_in = 1'b1;
                           else done_entry = 1'b1;
                        end
                     end
                     PH_LENGTH: begin
                        bbl_in = len_nx;
                        if (cnt_nx >= (shortv ? 4'd2 : 4'd4)) begin
                           cnt_in = 4'd0;
                           if (len_nx == 32'd0) begin
                              phase_in = PH_COUNT;
                              idx_in   = 9'd0;
                              pr_in    = 8'd0;
                              aw_in    = 1'b0;
                           end else begin
                              phase_in = PH_DATA;
                           end
                        end else begin
                           cnt_in = cnt_nx;
                        end
                     end
                     PH_DATA: begin
                        if (bbl_ff != 32'd0) bbl_in = bbl_ff - 32'd1;
                        c_in      = b;
                        tbl_raddr = b;
                        state_in  = S_CHK;
                     end
                     default: begin
                     end
                  endcase
                  if (done_entry) begin
                     idx_in = idx_nx;
                     pr_in  = pr_nx;
                     aw_in  = 1'b0;
                     if (idx_nx[8]) begin
                        phase_in = PH_LENGTH;
                        cnt_in   = 4'd0;
                        bbl_in   = 32'd0;
                     end else if (pr_nx == 8'd0) begin
                        phase_in = PH_COUNT;
                     end
                  end
               end
            end
         end
         S_POP: begin
            c_in      = stk_rd_ff;
            tbl_raddr = stk_rd_ff;
            state_in  = S_CHK;
         end
         S_CHK: begin
            if (rd_left_ff == c_ff) begin
               res_valid_in = 1'b1;
               state_in     = S_FIN;
            end else if (sp_ff >= SP_W'(STACK_DEPTH)) begin
               sp_in         = '0;
               res_status_in = ST_OVERFLOW;
               state_in      = S_FIN;
            end else begin
               sw_en     = 1'b1;
               sp_in     = sp_ff + 1'b1;
               c_in      = rd_left_ff;
               tbl_raddr = rd_left_ff;
            end
         end
         S_FILL: begin
            if (run_ff != 8'd0 && !idx_ff[8]) begin
               lw_en   = 1'b1;
               lw_data = idx_ff[7:0];
               idx_in  = idx_nx;
               run_in  = run_ff - 8'd1;
            end else begin
               state_in = S_FIN;
               pr_in    = 8'd1;
               if (idx_ff[8]) begin
                  idx_in   = 9'(PAIR_ENTRIES);
                  pr_in    = 8'd0;
                  phase_in = PH_LENGTH;
                  cnt_in   = 4'd0;
                  bbl_in   = 32'd0;
               end else begin
                  phase_in = PH_PAIR;
                  aw_in    = 1'b0;
               end
            end
         end
         S_FIN: begin
            if (phase_ff == PH_DATA && bbl_ff == 32'd0 && sp_ff == '0) begin
               phase_in = PH_COUNT;
               idx_in   = 9'd0;
               pr_in    = 8'd0;
               aw_in    = 1'b0;
            end
            if (!ov_ff || rsp_ch.ready) begin
               ov_in     = 1'b1;
               o_bv_in   = res_valid_ff;
               o_byte_in = res_valid_ff ? c_ff : 8'd0;
               o_pend_in = (sp_ff != '0);
               o_stat_in = res_status_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (lw_en) left_mem[idx_ff[7:0]] <= lw_data;
      if (rw_en) right_mem[idx_ff[7:0]] <= cmd.data;
      rd_left_ff  <= left_mem[tbl_raddr];
      rd_right_ff <= right_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (sw_en) stack_mem[sp_ff[STK_AW-1:0]] <= rd_right_ff;
      stk_rd_ff <= stack_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      c_ff          <= c_in;
      run_ff        <= run_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
      o_bv_ff       <= o_bv_in;
      o_byte_ff     <= o_byte_in;
      o_pend_ff     <= o_pend_in;
      o_stat_ff     <= o_stat_in;
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_HEADER;
         cnt_ff   <= 4'd0;
         short_ff <= 1'b0;
         idx_ff   <= 9'd0;
         pr_ff    <= 8'd0;
         aw_ff    <= 1'b0;
         bbl_ff   <= 32'd0;
         sp_ff    <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         short_ff <= short_in;
         idx_ff   <= idx_in;
         pr_ff    <= pr_in;
         aw_ff    <= aw_in;
         bbl_ff   <= bbl_in;
         sp_ff    <= sp_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.byte_valid   = o_bv_ff;
   assign rsp_ch.decoded_byte = o_byte_ff;
   assign rsp_ch.pending      = o_pend_ff;
   assign rsp_ch.status       = o_stat_ff;

endmodule
